// ----- hdl/lta_pkg.sv -----
// shared types, constants and the reciprocal table for the time-on-air pipeline
package lta_pkg;

	localparam int LEN_W    = 8;
	localparam int BWC_W    = 2;
	localparam int SF_W     = 4;
	localparam int CR_W     = 3;
	localparam int PRE_W    = 8;
	localparam int CFG_W    = 8;
	localparam int AIR_W    = 28;
	localparam int NUM_W    = 10;
	localparam int RECIP_W  = 14;
	localparam int RECIP_SH = 13;
	localparam int BLK_W    = 10;
	localparam int QTR_W    = 15;

	localparam logic [BWC_W-1:0] BWC_RESET = 2'd0;
	localparam logic [SF_W-1:0]  SF_RESET  = 4'd7;
	localparam logic [CR_W-1:0]  CR_RESET  = 3'd1;
	localparam logic [PRE_W-1:0] PRE_RESET = 8'd8;

	localparam logic [BWC_W-1:0] BWC_INVALID = 2'd3;

	typedef enum logic [1:0] {
		REG_BANDWIDTH = 2'd0,
		REG_SPREADING = 2'd1,
		REG_CODING    = 2'd2,
		REG_PREAMBLE  = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [BWC_W-1:0] bandwidth_code;
		logic [SF_W-1:0]  spreading_factor;
		logic [CR_W-1:0]  coding_rate;
		logic [PRE_W-1:0] preamble_length;
	} cfg_t;

	typedef struct packed {
		logic [BLK_W-1:0] blocks;
		logic             err;
	} quot_t;

	// ceil(2^13 / sf)
	function automatic logic [RECIP_W-1:0] recip(input logic [SF_W-1:0] sf);
		logic [RECIP_W-1:0] r;
		case (sf)
			4'd1:    r = 14'd8192;
			4'd2:    r = 14'd4096;
			4'd3:    r = 14'd2731;
			4'd4:    r = 14'd2048;
			4'd5:    r = 14'd1639;
			4'd6:    r = 14'd1366;
			4'd7:    r = 14'd1171;
			4'd8:    r = 14'd1024;
			4'd9:    r = 14'd911;
			4'd10:   r = 14'd820;
			4'd11:   r = 14'd745;
			4'd12:   r = 14'd683;
			4'd13:   r = 14'd631;
			4'd14:   r = 14'd586;
			4'd15:   r = 14'd547;
			default: r = 14'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/lta_quot.sv -----
// stages 1 and 2: payload block count by reciprocal multiply
module lta_quot (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  logic [lta_pkg::LEN_W-1:0] payload_length,
	input  lta_pkg::cfg_t             cfg,
	output logic                      down_valid,
	input  logic                      down_ready,
	output lta_pkg::quot_t            down_data
);
	import lta_pkg::*;

	logic                 v_s1, v_s2;
	logic [NUM_W-1:0]     num_s1;
	logic [RECIP_W-1:0]   recip_s1;
	logic                 err_s1;
	quot_t                data_s2;
	logic                 rdy_s1, rdy_s2;
	logic [NUM_W+RECIP_W-1:0] prod;

	assign rdy_s2   = !v_s2 || down_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// floor((2*len + 5) / sf) equals the ceil term, zero when the numerator is not positive
	assign prod = num_s1 * recip_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			num_s1   <= {1'b0, payload_length, 1'b0} + NUM_W'(5);
			recip_s1 <= recip(cfg.spreading_factor);
			err_s1   <= (cfg.bandwidth_code == BWC_INVALID) ||
			            (cfg.spreading_factor == '0);
		end
		if (rdy_s2 && v_s1) begin
			data_s2.blocks <= prod[RECIP_SH +: BLK_W];
			data_s2.err    <= err_s1;
		end
	end

	assign down_valid = v_s2;
	assign down_data  = data_s2;

endmodule

// ----- hdl/lta_time.sv -----
// stages 3 and 4: quarter-symbol count and scaling to microseconds
module lta_time (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  lta_pkg::quot_t            up_data,
	input  lta_pkg::cfg_t             cfg,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [lta_pkg::AIR_W-1:0] airtime_us,
	output logic                      config_error
);
	import lta_pkg::*;

	localparam int PROD_W = BLK_W + CR_W + 1;
	localparam int SH_W   = QTR_W + (1 << SF_W);

	logic                 v_s3, v_s4;
	logic [QTR_W-1:0]     qtr_s3;
	logic                 err_s3;
	logic [AIR_W-1:0]     air_s4;
	logic                 err_s4;
	logic                 rdy_s3, rdy_s4;
	logic [PROD_W-1:0]    sym_prod;
	logic [QTR_W-1:0]     qtr;
	logic [SH_W-1:0]      shifted;
	logic [SH_W-1:0]      scaled;

	assign rdy_s4   = !v_s4 || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign up_ready = rdy_s3;

	// 4*pre + 17 + 4*(8 + blocks*(cr+4))
	assign sym_prod = up_data.blocks * ({1'b0, cfg.coding_rate} + (CR_W+1)'(4));
	assign qtr      = QTR_W'({cfg.preamble_length, 2'b00}) + QTR_W'(49) +
	                  QTR_W'({sym_prod, 2'b00});

	assign shifted = SH_W'(qtr_s3) << ({1'b0, cfg.spreading_factor} + (SF_W+1)'(1));
	assign scaled  = shifted >> cfg.bandwidth_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= up_valid;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && up_valid) begin
			qtr_s3 <= qtr;
			err_s3 <= up_data.err;
		end
		if (rdy_s4 && v_s3) begin
			air_s4 <= err_s3 ? '0 : scaled[AIR_W-1:0];
			err_s4 <= err_s3;
		end
	end

	assign out_valid    = v_s4;
	assign airtime_us   = air_s4;
	assign config_error = err_s4;

endmodule

// ----- hdl/lora_time_on_air.sv -----
// top level: configuration registers and the four-stage time-on-air pipeline
// A transaction on the input carries one payload length; the result (time on air in
// microseconds and the configuration error flag) is registered through stages 1 to 4.
// The pipeline takes one transaction every cycle unless the input stalls; it stalls only
// while the output is stalled and every stage is full. The block count uses a
// reciprocal table and one 10x14 multiplier in stage 2, the symbol count a small
// multiply in stage 3 and the scaling a barrel shift in stage 4. Configuration
// registers are written with cfg_write and are to be changed only while the pipeline
// is empty.
module lora_time_on_air (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [1:0]                cfg_index,
	input  logic [lta_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [lta_pkg::LEN_W-1:0] payload_length,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [lta_pkg::AIR_W-1:0] airtime_us,
	output logic                      config_error
);
	import lta_pkg::*;

	cfg_t  cfg_q;
	logic  in_ready;
	logic  mid_valid, mid_ready;
	quot_t mid_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bandwidth_code   <= BWC_RESET;
			cfg_q.spreading_factor <= SF_RESET;
			cfg_q.coding_rate      <= CR_RESET;
			cfg_q.preamble_length  <= PRE_RESET;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_BANDWIDTH: cfg_q.bandwidth_code   <= cfg_data[BWC_W-1:0];
				REG_SPREADING: cfg_q.spreading_factor <= cfg_data[SF_W-1:0];
				REG_CODING:    cfg_q.coding_rate      <= cfg_data[CR_W-1:0];
				REG_PREAMBLE:  cfg_q.preamble_length  <= cfg_data[PRE_W-1:0];
				default: ;
			endcase
		end
	end

	lta_quot u_quot (
		.clk            (clk),
		.arst_n         (arst_n),
		.up_valid       (in_valid),
		.up_ready       (in_ready),
		.payload_length (payload_length),
		.cfg            (cfg_q),
		.down_valid     (mid_valid),
		.down_ready     (mid_ready),
		.down_data      (mid_data)
	);

	lta_time u_time (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (mid_valid),
		.up_ready     (mid_ready),
		.up_data      (mid_data),
		.cfg          (cfg_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.airtime_us   (airtime_us),
		.config_error (config_error)
	);

	assign in_stall = !in_ready;

	// input backs up only when the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output free");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && config_error) |-> (airtime_us == '0))
		else $error("nonzero time with config error");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !config_error) |-> (airtime_us != '0))
		else $error("zero time on valid config");

	// a free output never stalls the input
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("stall without downstream backpressure");

endmodule
